>>> src/bpa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_pkg
// Types, constants and controller/datapath links of the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int NUM_PAGES      = 32768;
	localparam int RESERVED_PAGES = 256;
	localparam int PAGE_BYTES     = 4096;

	localparam int RSV_EFF    = (RESERVED_PAGES < NUM_PAGES) ? RESERVED_PAGES : NUM_PAGES;
	localparam int ADDR_W     = 32;
	localparam int PADDR_W    = 27;
	localparam int CNT_W      = 16;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

	// The map is held as words of used bits, one bit per page.
	localparam int WORD_W = 32;
	localparam int BIT_W  = $clog2(WORD_W);
	localparam int WORDS  = (NUM_PAGES + WORD_W - 1) / WORD_W;
	localparam int WIDX_W = $clog2(WORDS);
	localparam int PG_W   = WIDX_W + BIT_W;

	typedef enum logic [1:0] {
		ST_ALLOC   = 2'd0,
		ST_NOFREE  = 2'd1,
		ST_FREED   = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef struct packed {
		logic              operation;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [PADDR_W-1:0] page_address;
		logic [CNT_W-1:0]   free_pages;
	} rsp_t;

	typedef struct packed {
		logic clr_step;
		logic accept;
		logic rd_issue;
		logic scan_next;
		logic commit;
		logic emit_direct;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic need_mem;
		logic is_alloc;
		logic word_full;
		logic slot_free;
	} sts_t;

endpackage
`default_nettype wire

>>> src/bitmap_page_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit physical page allocator with one used bit per page.
// ----------------------------------------------------------------------------
// An accepted request reads its map word (S_CHECK, S_EVAL), or is answered from
// S_CHECK when the map is not read; an allocation scan reads again in S_READ for
// each full word of 32 pages that it steps over. One request is in progress at a
// time; the next is taken once the result is in the output register. After reset
// a clearing pass writes the initial map (reserved pages used) through the single
// memory write port; no request is accepted until it finishes.
module bitmap_page_allocator (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire bpa_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output bpa_pkg::rsp_t      rsp
);
	import bpa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bpa_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

>>> src/bpa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer: clearing pass, request acceptance, word scan, and commit or direct result.
// ----------------------------------------------------------------------------
module bpa_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire bpa_pkg::sts_t sts,
	output bpa_pkg::cmd_t      cmd
);
	import bpa_pkg::*;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_CHECK = 5'b00100,
		S_READ  = 5'b01000,
		S_EVAL  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.need_mem) begin
					cmd.rd_issue = 1'b1;
					state_d      = S_EVAL;
				end else if (sts.slot_free) begin
					cmd.emit_direct = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_READ: begin
				cmd.rd_issue = 1'b1;
				state_d      = S_EVAL;
			end
			S_EVAL: begin
				// A full word during an allocation moves the scan to the next word.
				if (sts.is_alloc && sts.word_full) begin
					cmd.scan_next = 1'b1;
					state_d       = S_READ;
				end else if (sts.slot_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

>>> src/bpa_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_datapath
// Used-bit word memory, scan hint, free-page count and result register.
// ----------------------------------------------------------------------------
module bpa_datapath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bpa_pkg::req_t req,
	input  wire bpa_pkg::cmd_t cmd,
	output bpa_pkg::sts_t      sts,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output bpa_pkg::rsp_t      rsp
);
	import bpa_pkg::*;

	localparam logic [CNT_W-1:0]  CNT_RESET  = CNT_W'(NUM_PAGES - RSV_EFF);
	localparam logic [WIDX_W-1:0] HINT_RESET = WIDX_W'(RSV_EFF / WORD_W);
	localparam logic [WIDX_W-1:0] LAST_WORD  = WIDX_W'(WORDS - 1);
	localparam logic [PG_W:0]     NUM_PG_L   = (PG_W + 1)'(NUM_PAGES);
	localparam logic [PG_W:0]     RSV_PG_L   = (PG_W + 1)'(RSV_EFF);
	localparam int                HI_W       = ADDR_W - PAGE_SHIFT - PG_W;
	localparam int                PA_FULL_W  = PG_W + PAGE_SHIFT;

	// Value written by the clearing pass: reserved pages and pages past the end
	// read as used, so the scan never returns them.
	function automatic logic [WORD_W-1:0] reset_word(input logic [WIDX_W-1:0] idx);
		logic [WORD_W-1:0] w;
		logic [PG_W:0]     pg;
		w = '0;
		for (int b = 0; b < WORD_W; b++) begin
			pg   = {1'b0, idx, BIT_W'(b)};
			w[b] = (pg < RSV_PG_L) || (pg >= NUM_PG_L);
		end
		return w;
	endfunction

	function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_W-1:0] w);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!w[i]) idx = BIT_W'(i);
		end
		return idx;
	endfunction

	logic [WORD_W-1:0] mem [WORDS];

	logic [WIDX_W-1:0] clr_idx_q;
	logic [WIDX_W-1:0] hint_q;
	logic [CNT_W-1:0]  count_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;
	logic              op_q;
	logic [PG_W-1:0]   page_q;
	logic              page_ok_q;
	logic [WIDX_W-1:0] waddr_q;
	logic [WORD_W-1:0] rd_q;

	logic [PG_W-1:0]     req_page;
	logic                req_page_ok;
	logic [BIT_W-1:0]    sel_bit;
	logic [WORD_W-1:0]   bit_mask;
	logic                bit_used;
	logic                do_write;
	logic [WIDX_W-1:0]   wr_addr;
	logic [WORD_W-1:0]   wr_data;
	logic                slot_free;
	logic [PA_FULL_W-1:0] pa_full;

	assign req_page    = req.address[PAGE_SHIFT +: PG_W];
	assign req_page_ok = (req.address[ADDR_W-1 -: HI_W] == '0)
		&& ({1'b0, req_page} < NUM_PG_L) && ({1'b0, req_page} >= RSV_PG_L);

	assign sel_bit  = (op_q == OP_ALLOC) ? lowest_zero(rd_q) : page_q[BIT_W-1:0];
	assign bit_mask = WORD_W'(1) << sel_bit;
	assign bit_used = |(rd_q & bit_mask);
	assign pa_full  = {waddr_q, sel_bit, PAGE_SHIFT'(0)};

	assign slot_free = !rsp_valid_q || rsp_ready;

	assign sts.clr_last  = (clr_idx_q == LAST_WORD);
	assign sts.need_mem  = (op_q == OP_ALLOC) ? (count_q != '0) : page_ok_q;
	assign sts.is_alloc  = (op_q == OP_ALLOC);
	assign sts.word_full = &rd_q;
	assign sts.slot_free = slot_free;

	always_comb begin
		do_write = 1'b0;
		wr_addr  = waddr_q;
		wr_data  = rd_q;
		if (cmd.clr_step) begin
			do_write = 1'b1;
			wr_addr  = clr_idx_q;
			wr_data  = reset_word(clr_idx_q);
		end else if (cmd.commit) begin
			if (op_q == OP_ALLOC) begin
				do_write = 1'b1;
				wr_data  = rd_q | bit_mask;
			end else if (bit_used) begin
				do_write = 1'b1;
				wr_data  = rd_q & ~bit_mask;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) mem[wr_addr] <= wr_data;
		if (cmd.rd_issue) rd_q <= mem[waddr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q      <= req.operation;
			page_q    <= req_page;
			page_ok_q <= req_page_ok;
			waddr_q   <= (req.operation == OP_ALLOC) ? hint_q : req_page[PG_W-1:BIT_W];
		end else if (cmd.scan_next) begin
			waddr_q <= waddr_q + WIDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
			hint_q    <= HINT_RESET;
			count_q   <= CNT_RESET;
		end else begin
			if (cmd.clr_step) clr_idx_q <= clr_idx_q + WIDX_W'(1);
			if (cmd.commit) begin
				if (op_q == OP_ALLOC) begin
					// Every word below the one just used is full.
					hint_q  <= waddr_q;
					count_q <= count_q - CNT_W'(1);
				end else if (bit_used) begin
					if (waddr_q < hint_q) hint_q <= waddr_q;
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit || cmd.emit_direct) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_direct) begin
			rsp_q.status       <= (op_q == OP_ALLOC) ? ST_NOFREE : ST_IGNORED;
			rsp_q.page_address <= '0;
			rsp_q.free_pages   <= count_q;
		end else if (cmd.commit) begin
			if (op_q == OP_ALLOC) begin
				rsp_q.status       <= ST_ALLOC;
				rsp_q.page_address <= pa_full[PADDR_W-1:0];
				rsp_q.free_pages   <= count_q - CNT_W'(1);
			end else begin
				rsp_q.status       <= bit_used ? ST_FREED : ST_IGNORED;
				rsp_q.page_address <= '0;
				rsp_q.free_pages   <= bit_used ? count_q + CNT_W'(1) : count_q;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.commit && cmd.emit_direct))
		else $error("commit and direct result in the same cycle");

	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit || cmd.emit_direct) |-> slot_free)
		else $error("result loaded over a pending transaction");

	a_alloc_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && op_q == OP_ALLOC) |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("allocation did not take one page from the count");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_RESET)
		else $error("free-page count above its reset value");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_next |-> (count_q != '0) && (waddr_q != LAST_WORD))
		else $error("scan ran past the last word");

endmodule
`default_nettype wire
